>>> design/srcc_pkg.sv
package srcc_pkg;

  // Command codes of the request channel
  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_START    = 3'd1,
    CMD_STOP     = 3'd2,
    CMD_PAUSE    = 3'd3,
    CMD_ADD_TIME = 3'd4
  } srcc_cmd_e;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_START_PERIOD  = 3'd0,
    REG_TARGET_PERIOD = 3'd1,
    REG_PULSE_WIDTH   = 3'd2,
    REG_SECOND_RELOAD = 3'd3,
    REG_LAMP_ENABLE   = 3'd4
  } srcc_reg_e;

  localparam int unsigned AddrWidth = 5;

  localparam logic [15:0] StartPeriodRst  = 16'd1000;
  localparam logic [15:0] TargetPeriodRst = 16'd26;
  localparam logic [15:0] PulseWidthRst   = 16'd15;
  localparam logic [15:0] SecondReloadRst = 16'd10000;
  localparam logic [15:0] SecondsLeftRst  = 16'd60;
  localparam logic [15:0] AddSeconds      = 16'd60;

  // ceil(2^20 / 20): exact quotient for every 16-bit dividend
  localparam logic [15:0] Recip20 = 16'd52429;

  typedef struct packed {
    logic [15:0] start_period;
    logic [15:0] target_period;
    logic [15:0] pulse_width;
    logic [15:0] second_reload;
    logic        lamp_enable;
  } srcc_cfg_t;

  typedef struct packed {
    logic        step_out;
    logic        drive_enable;
    logic        lamp_on;
    logic [15:0] remaining_seconds;
    logic        ramping;
    logic        finished;
    logic        rejected;
  } srcc_res_t;

  // x / 20 by reciprocal multiplication
  function automatic logic [15:0] div20(logic [15:0] x);
    logic [31:0] prod;
    prod = x * Recip20;
    return {4'd0, prod[31:20]};
  endfunction

endpackage

>>> design/srcc_if.sv
// Command request channel
interface srcc_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] duration_seconds;

  modport source (output valid, cmd, duration_seconds, input ready);
  modport sink (input valid, cmd, duration_seconds, output ready);
endinterface

// Status result channel
interface srcc_res_if;
  logic        valid;
  logic        ready;
  logic        step_out;
  logic        drive_enable;
  logic        lamp_on;
  logic [15:0] remaining_seconds;
  logic        ramping;
  logic        finished;
  logic        rejected;

  modport source (output valid, step_out, drive_enable, lamp_on, remaining_seconds,
                  ramping, finished, rejected, input ready);
  modport sink (input valid, step_out, drive_enable, lamp_on, remaining_seconds,
                ramping, finished, rejected, output ready);
endinterface

>>> design/srcc_cfg_regs.sv
module srcc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srcc_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output srcc_pkg::srcc_cfg_t             cfg_o
);
  import srcc_pkg::*;

  srcc_cfg_t cfg_q;
  logic      wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[AddrWidth-1:2];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_period  <= StartPeriodRst;
      cfg_q.target_period <= TargetPeriodRst;
      cfg_q.pulse_width   <= PulseWidthRst;
      cfg_q.second_reload <= SecondReloadRst;
      cfg_q.lamp_enable   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START_PERIOD:  cfg_q.start_period  <= pwdata[15:0];
        REG_TARGET_PERIOD: cfg_q.target_period <= pwdata[15:0];
        REG_PULSE_WIDTH:   cfg_q.pulse_width   <= pwdata[15:0];
        REG_SECOND_RELOAD: cfg_q.second_reload <= pwdata[15:0];
        REG_LAMP_ENABLE:   cfg_q.lamp_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_START_PERIOD:  prdata = {16'd0, cfg_q.start_period};
      REG_TARGET_PERIOD: prdata = {16'd0, cfg_q.target_period};
      REG_PULSE_WIDTH:   prdata = {16'd0, cfg_q.pulse_width};
      REG_SECOND_RELOAD: prdata = {16'd0, cfg_q.second_reload};
      REG_LAMP_ENABLE:   prdata = {31'd0, cfg_q.lamp_enable};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/srcc_core.sv
module srcc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srcc_pkg::srcc_cfg_t  cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           cmd_i,
  input  logic [15:0]          duration_seconds_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output srcc_pkg::srcc_res_t  res_o
);
  import srcc_pkg::*;

  // Input register
  logic        in_valid_q;
  logic [2:0]  cmd_q;
  logic [15:0] dur_q;

  // Controller state
  logic        running_q, running_d;
  logic        paused_q, paused_d;
  logic        level_q, level_d;
  logic [15:0] period_q, period_d;
  logic [15:0] step_cnt_q, step_cnt_d;
  logic [15:0] sec_cnt_q, sec_cnt_d;
  logic [15:0] secs_q, secs_d;

  // Result register
  logic        res_valid_q;
  srcc_res_t   res_q, res_d;

  logic        out_free;
  logic        fire;
  logic        rejected;
  logic [16:0] secs_sum;

  assign out_free   = ~res_valid_q | res_ready_i;
  assign fire       = in_valid_q & out_free;
  assign in_ready_o = ~in_valid_q | out_free;
  assign secs_sum   = {1'b0, secs_q} + {1'b0, AddSeconds};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= cmd_i;
      dur_q <= duration_seconds_i;
    end
  end

  // Next state for the command in the input register
  always_comb begin
    running_d  = running_q;
    paused_d   = paused_q;
    level_d    = level_q;
    period_d   = period_q;
    step_cnt_d = step_cnt_q;
    sec_cnt_d  = sec_cnt_q;
    secs_d     = secs_q;
    rejected   = 1'b0;

    unique case (cmd_q)
      CMD_TICK: begin
        if (running_q && !paused_q && secs_q != 16'd0) begin
          if (step_cnt_q == cfg_i.pulse_width) level_d = 1'b1;
          if (step_cnt_q == 16'd0) begin
            level_d = 1'b0;
            if (period_q > cfg_i.target_period) period_d = period_q - div20(period_q);
            step_cnt_d = period_d;
          end else begin
            step_cnt_d = step_cnt_q - 16'd1;
          end
          // seconds only count once the ramp is done
          if (sec_cnt_q == 16'd0) begin
            if (period_d <= cfg_i.target_period) secs_d = secs_q - 16'd1;
            sec_cnt_d = cfg_i.second_reload;
          end else begin
            sec_cnt_d = sec_cnt_q - 16'd1;
          end
        end
      end
      CMD_START: begin
        if (!running_q) begin
          running_d = 1'b1;
          paused_d  = 1'b0;
          secs_d    = dur_q;
        end
      end
      CMD_STOP: begin
        running_d = 1'b0;
        paused_d  = 1'b0;
        period_d  = cfg_i.start_period;
        level_d   = 1'b0;
      end
      CMD_PAUSE: begin
        if (running_q && secs_q != 16'd0) begin
          paused_d = ~paused_q;
          if (!paused_q) begin
            period_d = cfg_i.start_period;
            level_d  = 1'b0;
          end
        end else begin
          rejected = 1'b1;
        end
      end
      CMD_ADD_TIME: begin
        if (running_q) secs_d = secs_sum[16] ? 16'hFFFF : secs_sum[15:0];
      end
      default: ;
    endcase

    // finished run: back to start period, step line low
    if (running_d && !paused_d && secs_d == 16'd0) begin
      period_d = cfg_i.start_period;
      level_d  = 1'b0;
    end

    res_d.step_out          = level_d;
    res_d.drive_enable      = running_d & ~paused_d;
    res_d.lamp_on           = cfg_i.lamp_enable & running_d & ~paused_d & (secs_d != 16'd0);
    res_d.remaining_seconds = secs_d;
    res_d.ramping           = period_d > cfg_i.target_period;
    res_d.finished          = running_d & (secs_d == 16'd0);
    res_d.rejected          = rejected;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      paused_q   <= 1'b0;
      level_q    <= 1'b0;
      period_q   <= StartPeriodRst;
      step_cnt_q <= StartPeriodRst;
      sec_cnt_q  <= SecondReloadRst;
      secs_q     <= SecondsLeftRst;
    end else if (fire) begin
      running_q  <= running_d;
      paused_q   <= paused_d;
      level_q    <= level_d;
      period_q   <= period_d;
      step_cnt_q <= step_cnt_d;
      sec_cnt_q  <= sec_cnt_d;
      secs_q     <= secs_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_pause_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    paused_q |-> running_q) else $error("paused while not running");

  a_lamp_needs_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.lamp_on |-> res_q.drive_enable)
    else $error("lamp on without drive");

  a_finish_drops_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.finished && res_q.drive_enable |-> !res_q.step_out)
    else $error("step line high after finish");

  a_reject_only_pause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && cmd_q != CMD_PAUSE |=> !res_q.rejected)
    else $error("reject flagged on non-pause command");

endmodule

>>> design/stepper_ramp_countdown_controller.sv
// Stepper pulse generator with acceleration ramp and run timer. Each accepted
// request (tick, start, stop, pause toggle, add sixty seconds) produces one
// status result. The block takes one request per clock cycle while the result
// channel keeps up; an accepted request loads the input register, and the state
// and the result register are loaded from it once the result register is free,
// so the throughput is set only by the result channel's ready. Ramp steps
// shrink the period by period/20 using a 16x16 reciprocal multiply in the
// single update stage. Registers on the APB port (start_period 0x00,
// target_period 0x04, pulse_width 0x08, second_reload 0x0C, lamp_enable 0x10)
// should be written while no request is in flight; writes never disturb the
// running state.
module stepper_ramp_countdown_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  srcc_cmd_if.sink                        cmd_if,
  srcc_res_if.source                      res_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [srcc_pkg::AddrWidth-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import srcc_pkg::*;

  srcc_cfg_t cfg;
  srcc_res_t res;

  srcc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  srcc_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .in_valid_i         (cmd_if.valid),
    .in_ready_o         (cmd_if.ready),
    .cmd_i              (cmd_if.cmd),
    .duration_seconds_i (cmd_if.duration_seconds),
    .res_valid_o        (res_if.valid),
    .res_ready_i        (res_if.ready),
    .res_o              (res)
  );

  assign res_if.step_out          = res.step_out;
  assign res_if.drive_enable      = res.drive_enable;
  assign res_if.lamp_on           = res.lamp_on;
  assign res_if.remaining_seconds = res.remaining_seconds;
  assign res_if.ramping           = res.ramping;
  assign res_if.finished          = res.finished;
  assign res_if.rejected          = res.rejected;

endmodule

>>> test/stepper_ramp_countdown_controller_tb.sv
`timescale 1ns / 1ps

module stepper_ramp_countdown_controller_tb;
  import srcc_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam logic [15:0] RampDivisor = 16'd20;
  // Command codes the block treats as no operation
  localparam logic [2:0]  CmdSpare5   = 3'd5;
  localparam logic [2:0]  CmdSpare6   = 3'd6;
  localparam logic [2:0]  CmdSpare7   = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] dur;
  } motor_req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  srcc_cmd_if cmd_bus ();
  srcc_res_if res_bus ();

  stepper_ramp_countdown_controller u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_if  (cmd_bus),
    .res_if  (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock: 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Pending requests, expected status and register shadow
  motor_req_t  pending_reqs[$];
  srcc_res_t   status_due[$];
  srcc_cfg_t   cfg_shadow;
  motor_req_t  cur_req;
  srcc_res_t   status_new;
  srcc_res_t   status_want;
  int unsigned idle_pct;
  int unsigned n_errors   = 0;
  int unsigned n_sent     = 0;
  int unsigned n_checked  = 0;
  int unsigned n_ticks    = 0;
  int unsigned n_settings = 0;
  int unsigned stall_cnt  = 0;

  // Motor model state
  logic        mot_running;
  logic        mot_paused;
  logic        mot_step_lvl;
  logic [15:0] mot_period;
  logic [15:0] mot_step_cnt;
  logic [15:0] mot_sec_cnt;
  logic [15:0] mot_secs;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t result %0d: %s", $time, n_checked, what);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Stop, pause and finish put the period back and drop the step line
  task automatic restore_drive();
    mot_period   = cfg_shadow.start_period;
    mot_step_lvl = 1'b0;
  endtask

  // Expected status after one request, advancing the motor model
  task automatic predict_status(input motor_req_t req, output srcc_res_t st);
    logic        refused;
    logic [16:0] sum;
    refused = 1'b0;
    case (req.cmd)
      CMD_TICK: begin
        if (mot_running && !mot_paused && mot_secs != 16'd0) begin
          if (mot_step_cnt == cfg_shadow.pulse_width) mot_step_lvl = 1'b1;
          if (mot_step_cnt == 16'd0) begin
            mot_step_lvl = 1'b0;
            if (mot_period > cfg_shadow.target_period)
              mot_period = mot_period - mot_period / RampDivisor;
            mot_step_cnt = mot_period;
          end else begin
            mot_step_cnt = mot_step_cnt - 16'd1;
          end
          // seconds only count once at speed
          if (mot_sec_cnt == 16'd0) begin
            if (mot_period <= cfg_shadow.target_period) mot_secs = mot_secs - 16'd1;
            mot_sec_cnt = cfg_shadow.second_reload;
          end else begin
            mot_sec_cnt = mot_sec_cnt - 16'd1;
          end
        end
      end
      CMD_START: begin
        if (!mot_running) begin
          mot_running = 1'b1;
          mot_paused  = 1'b0;
          mot_secs    = req.dur;
        end
      end
      CMD_STOP: begin
        mot_running = 1'b0;
        mot_paused  = 1'b0;
        restore_drive();
      end
      CMD_PAUSE: begin
        if (mot_running && mot_secs != 16'd0) begin
          mot_paused = !mot_paused;
          if (mot_paused) restore_drive();
        end else begin
          refused = 1'b1;
        end
      end
      CMD_ADD_TIME: begin
        if (mot_running) begin
          sum      = {1'b0, mot_secs} + {1'b0, AddSeconds};
          mot_secs = sum[16] ? 16'hFFFF : sum[15:0];
        end
      end
      default: ;
    endcase
    // run finished: out of time while driving
    if (mot_running && !mot_paused && mot_secs == 16'd0) restore_drive();
    st.step_out          = mot_step_lvl;
    st.drive_enable      = mot_running && !mot_paused;
    st.lamp_on           = cfg_shadow.lamp_enable && mot_running && !mot_paused &&
                           mot_secs != 16'd0;
    st.remaining_seconds = mot_secs;
    st.ramping           = mot_period > cfg_shadow.target_period;
    st.finished          = mot_running && mot_secs == 16'd0;
    st.rejected          = refused;
  endtask

  // Request driver: predicts on accept, then loads the next pending request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_bus.valid            <= 1'b0;
      cmd_bus.cmd              <= CMD_TICK;
      cmd_bus.duration_seconds <= '0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        predict_status(cur_req, status_new);
        status_due.push_back(status_new);
        n_sent++;
      end
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_req                   = pending_reqs.pop_front();
          cmd_bus.valid            <= 1'b1;
          cmd_bus.cmd              <= cur_req.cmd;
          cmd_bus.duration_seconds <= cur_req.dur;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Status monitor with random backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (status_due.size() == 0) begin
          report_mismatch("status with no request outstanding");
        end else begin
          status_want = status_due.pop_front();
          check_field("step_out", 16'(res_bus.step_out), 16'(status_want.step_out));
          check_field("drive_enable", 16'(res_bus.drive_enable),
                      16'(status_want.drive_enable));
          check_field("lamp_on", 16'(res_bus.lamp_on), 16'(status_want.lamp_on));
          check_field("remaining_seconds", res_bus.remaining_seconds,
                      status_want.remaining_seconds);
          check_field("ramping", 16'(res_bus.ramping), 16'(status_want.ramping));
          check_field("finished", 16'(res_bus.finished), 16'(status_want.finished));
          check_field("rejected", 16'(res_bus.rejected), 16'(status_want.rejected));
        end
        n_checked++;
      end
      res_bus.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog: no traffic on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (cmd_bus.valid && cmd_bus.ready) ||
        (res_bus.valid && res_bus.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("Timeout: no traffic for %0d cycles, %0d status pending",
               stall_cnt, status_due.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic push_req(input logic [2:0] c, input logic [15:0] d);
    pending_reqs.push_back({c, d});
    if (c == CMD_TICK) n_ticks++;
  endtask

  // APB write, then read back the same register
  task automatic write_reg(input srcc_reg_e idx, input logic [15:0] val);
    logic [15:0] want;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    want = val;
    case (idx)
      REG_START_PERIOD:  cfg_shadow.start_period  = val;
      REG_TARGET_PERIOD: cfg_shadow.target_period = val;
      REG_PULSE_WIDTH:   cfg_shadow.pulse_width   = val;
      REG_SECOND_RELOAD: cfg_shadow.second_reload = val;
      REG_LAMP_ENABLE: begin
        cfg_shadow.lamp_enable = val[0];
        want                   = {15'd0, val[0]};
      end
      default: ;
    endcase
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== want)
      report_mismatch($sformatf("register %s reads %0h want %0h", idx.name(),
                                prdata[15:0], want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] sp, input logic [15:0] tp,
                            input logic [15:0] pw, input logic [15:0] sr,
                            input logic le);
    write_reg(REG_START_PERIOD, sp);
    write_reg(REG_TARGET_PERIOD, tp);
    write_reg(REG_PULSE_WIDTH, pw);
    write_reg(REG_SECOND_RELOAD, sr);
    write_reg(REG_LAMP_ENABLE, {15'd0, le});
    n_settings++;
  endtask

  // Mostly runs: start, a burst of ticks with pause/add/stop mixed in; some noise
  task automatic queue_random(input int unsigned n);
    int unsigned count;
    int unsigned burst;
    int unsigned pick;
    count = 0;
    @(negedge clk_i);
    while (count < n) begin
      if ($urandom_range(99) < 80) begin
        push_req(CMD_START, ($urandom_range(7) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(6)));
        burst = $urandom_range(100, 4);
        count += burst + 1;
        repeat (burst) begin
          pick = $urandom_range(99);
          if (pick < 82)      push_req(CMD_TICK, 16'($urandom));
          else if (pick < 87) push_req(CMD_PAUSE, 16'($urandom));
          else if (pick < 92) push_req(CMD_ADD_TIME, 16'($urandom));
          else if (pick < 95) push_req(CMD_START, 16'($urandom));
          else if (pick < 97) push_req(CMD_STOP, 16'($urandom));
          else                push_req(3'($urandom_range(CmdSpare7, CmdSpare5)),
                                       16'($urandom));
        end
        if ($urandom_range(9) < 7) begin
          push_req(CMD_STOP, 16'($urandom));
          count++;
        end
      end else begin
        push_req(3'($urandom_range(7)), 16'($urandom));
        count++;
      end
    end
  endtask

  // Block until every request is sent and every status is back
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || cmd_bus.valid || status_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    rst_ni                   = 1'b0;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    idle_pct                 = 35;
    cfg_shadow = '{start_period: StartPeriodRst, target_period: TargetPeriodRst,
                   pulse_width: PulseWidthRst, second_reload: SecondReloadRst,
                   lamp_enable: 1'b0};
    mot_running  = 1'b0;
    mot_paused   = 1'b0;
    mot_step_lvl = 1'b0;
    mot_period   = StartPeriodRst;
    mot_step_cnt = StartPeriodRst;
    mot_sec_cnt  = SecondReloadRst;
    mot_secs     = SecondsLeftRst;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: commands while idle, zero-length run, pause/add corners
    @(negedge clk_i);
    push_req(CMD_TICK, 16'hFFFF);
    push_req(CMD_PAUSE, 16'd0);
    push_req(CMD_ADD_TIME, 16'd0);
    push_req(CMD_STOP, 16'd0);
    push_req(CmdSpare5, 16'hA5A5);
    push_req(CmdSpare6, 16'h5A5A);
    push_req(CmdSpare7, 16'hFFFF);
    push_req(CMD_START, 16'd0);
    push_req(CMD_PAUSE, 16'd0);
    push_req(CMD_TICK, 16'd0);
    push_req(CMD_ADD_TIME, 16'd0);
    push_req(CMD_START, 16'd500);
    repeat (3) push_req(CMD_TICK, 16'd0);
    push_req(CMD_PAUSE, 16'd0);
    push_req(CMD_ADD_TIME, 16'd0);
    push_req(CMD_TICK, 16'd0);
    push_req(CMD_PAUSE, 16'd0);
    push_req(CMD_STOP, 16'd0);
    push_req(CMD_START, 16'hFFFF);
    push_req(CMD_ADD_TIME, 16'd0);
    push_req(CMD_TICK, 16'd0);
    push_req(CMD_STOP, 16'd0);
    wait_drained();

    // Short ramp
    set_config(16'd25, 16'd21, 16'd4, 16'd3, 1'b1);
    queue_random(300);
    wait_drained();

    // No ramp, no idling on either side
    set_config(16'd8, 16'd8, 16'd2, 16'd1, 1'b0);
    @(negedge clk_i);
    idle_pct = 0;
    queue_random(250);
    wait_drained();
    @(negedge clk_i);
    idle_pct = 35;

    // Period below the shrink threshold: target never reached
    set_config(16'd10, 16'd1, 16'd3, 16'd2, 1'b1);
    queue_random(150);
    wait_drained();

    // Ramp of a few steps; the sender holds off mid-phase until all status is back
    set_config(16'd30, 16'd26, 16'd5, 16'd4, 1'b1);
    queue_random(150);
    wait_drained();
    queue_random(150);
    wait_drained();

    // Period of one, target at max, pulse width zero
    set_config(16'd1, 16'hFFFF, 16'd0, 16'd1, 1'b0);
    queue_random(150);
    wait_drained();

    // Largest values last, since their reloads would stall any later phase
    set_config(16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 1'b1);
    queue_random(150);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (status_due.size() != 0)
      report_mismatch($sformatf("%0d status never arrived", status_due.size()));
    $display("Covered %0d requests (%0d ticks) under %0d register settings",
             n_sent, n_ticks, n_settings);
    $display("Checked %0d status results, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
